// ----- design/row_filter_aggregate_assert.svh -----
// Assertion macros shared by the row filter and aggregate RTL.
`ifndef ROW_FILTER_AGGREGATE_ASSERT_SVH
`define ROW_FILTER_AGGREGATE_ASSERT_SVH

`ifndef SYNTHESIS
`define RFA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define RFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define RFA_ASSERT_SAME(label, clk, rst, ante, cons)
`define RFA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/rfa_pkg.sv -----
// Types, codes and helper functions of the row filter and aggregate block.
`default_nettype none
package rfa_pkg;

   localparam int COL_W       = 32;
   localparam int NUM_COLUMNS = 4;
   localparam int COUNT_W     = 21;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_CNT_W   = $clog2(COL_W);

   // aggregate function codes
   localparam logic [2:0] FN_COUNT_STAR = 3'd0;
   localparam logic [2:0] FN_COUNT      = 3'd1;
   localparam logic [2:0] FN_SUM        = 3'd2;
   localparam logic [2:0] FN_AVG        = 3'd3;
   localparam logic [2:0] FN_MIN        = 3'd4;
   localparam logic [2:0] FN_MAX        = 3'd5;

   // relation codes, column REL constant
   localparam logic [2:0] REL_EQ = 3'd0;
   localparam logic [2:0] REL_NE = 3'd1;
   localparam logic [2:0] REL_LT = 3'd2;
   localparam logic [2:0] REL_LE = 3'd3;
   localparam logic [2:0] REL_GT = 3'd4;
   localparam logic [2:0] REL_GE = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AGG_FUNCTION       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGG_COLUMN         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_COND_COLUMN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_COND_VALUE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_COND_COLUMN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_COND_VALUE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COND_OPS           = 3'd6;

   localparam logic [2:0] COL_NONE = 3'd4;

   typedef logic signed [COL_W-1:0] col_type;
   typedef logic [COUNT_W-1:0]      count_type;

   typedef struct packed {
      logic accept;
      logic fold;
      logic div_start;
      logic div_step;
      logic load_out;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic s1_last;
      logic need_div;
   } sts_type;

   function automatic logic rel_true(input logic [2:0] rel, input col_type a,
                                     input col_type b);
      logic r;
      case (rel)
         REL_EQ:  r = (a == b);
         REL_NE:  r = (a != b);
         REL_LT:  r = (a < b);
         REL_LE:  r = (a <= b);
         REL_GT:  r = (a > b);
         REL_GE:  r = (a >= b);
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // column selects at or beyond the table width never hold an integer
   function automatic logic col_is_int(input logic [2:0] col, input logic [3:0] present);
      logic r;
      r = 1'b0;
      if (!col[2] && (int'(col) < NUM_COLUMNS))
         r = present[col[1:0]];
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- design/row_filter_aggregate.sv -----
// Row filter and aggregate top level: one row per cycle is filtered and folded in.
// A last row's result is loaded after its fold stage and the ST_FIN state; with AVG and
// a nonzero count the 32-step shift-subtract divider runs before the load.
// Rows stall from the cycle after a last row until its result is in the output register.
// Synchronous active-high reset clears control, counts and the accumulator, and
// loads the registers with their defaults (both condition columns 4, all else 0).
`default_nettype none
`include "row_filter_aggregate_assert.svh"
module row_filter_aggregate (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rfa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [rfa_pkg::COL_W-1:0] req_col_zero,
   input  wire logic signed [rfa_pkg::COL_W-1:0] req_col_one,
   input  wire logic signed [rfa_pkg::COL_W-1:0] req_col_two,
   input  wire logic signed [rfa_pkg::COL_W-1:0] req_col_three,
   input  wire logic [3:0]                       req_int_present,
   input  wire logic                             req_last_row,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [rfa_pkg::COL_W-1:0]      rsp_agg_value,
   output logic [rfa_pkg::COUNT_W-1:0]           rsp_matched_rows,
   output logic [rfa_pkg::COUNT_W-1:0]           rsp_values_used
);
   import rfa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   rfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   rfa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_col_zero     (req_col_zero),
      .req_col_one      (req_col_one),
      .req_col_two      (req_col_two),
      .req_col_three    (req_col_three),
      .req_int_present  (req_int_present),
      .req_last_row     (req_last_row),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_agg_value    (rsp_agg_value),
      .rsp_matched_rows (rsp_matched_rows),
      .rsp_values_used  (rsp_values_used)
   );

   `RFA_ASSERT_NEXT(a_last_row_stalls, clock, reset, req_valid && !req_stall && req_last_row, req_stall)
   `RFA_ASSERT_SAME(a_used_le_matched, clock, reset, rsp_valid, rsp_values_used <= rsp_matched_rows)
   `RFA_ASSERT_SAME(a_no_fold_at_load, clock, reset, cmd.load_out, !cmd.fold && !cmd.accept)

endmodule
`default_nettype wire

// ----- design/rfa_ctrl.sv -----
// Controller: row acceptance, end-of-table sequencing, divide steps, result handoff.
`default_nettype none
module rfa_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rfa_pkg::cmd_type     cmd,
   input  wire rfa_pkg::sts_type sts
);
   import rfa_pkg::*;

   typedef enum logic [2:0] {
      ST_ROW = 3'b001,
      ST_FIN = 3'b010,
      ST_DIV = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic                   accept;
   logic                   out_free;

   // hold rows while a last row is still in the fold stage or the state is not ST_ROW
   assign req_stall = (state_ff != ST_ROW) || (s1_valid_ff && sts.s1_last);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      done_in       = done_ff;
      s1_valid_in   = accept;
      cmd           = '0;
      cmd.accept    = accept;
      cmd.fold      = s1_valid_ff;
      case (state_ff)
         ST_ROW: begin
            if (s1_valid_ff && sts.s1_last)
               state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               done_in       = 1'b0;
               state_in      = ST_DIV;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = ST_ROW;
            end
         end
         ST_DIV: begin
            if (!done_ff) begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == DIV_CNT_W'(COL_W - 1))
                  done_in = 1'b1;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               done_in      = 1'b0;
               state_in     = ST_ROW;
            end
         end
         default: begin
            state_in = ST_ROW;
         end
      endcase
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ROW;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/rfa_dp.sv -----
// Datapath: registers, row filter, fold stage, shift-subtract divider, result register.
`default_nettype none
module rfa_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [rfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rfa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic signed [rfa_pkg::COL_W-1:0] req_col_zero,
   input  wire logic signed [rfa_pkg::COL_W-1:0] req_col_one,
   input  wire logic signed [rfa_pkg::COL_W-1:0] req_col_two,
   input  wire logic signed [rfa_pkg::COL_W-1:0] req_col_three,
   input  wire logic [3:0]                       req_int_present,
   input  wire logic                             req_last_row,
   input  wire rfa_pkg::cmd_type                 cmd,
   output rfa_pkg::sts_type                      sts,
   output logic signed [rfa_pkg::COL_W-1:0]      rsp_agg_value,
   output logic [rfa_pkg::COUNT_W-1:0]           rsp_matched_rows,
   output logic [rfa_pkg::COUNT_W-1:0]           rsp_values_used
);
   import rfa_pkg::*;

   // configuration
   logic [2:0]       func_ff;
   logic [1:0]       agg_col_ff;
   logic [2:0]       c1_col_ff, c2_col_ff;
   col_type          c1_val_ff, c2_val_ff;
   logic [6:0]       ops_ff;

   // filter stage
   col_type          cols [NUM_COLUMNS];
   logic             r1, r2, pass, agg_int;
   logic             s1_pass_ff, s1_use_ff, s1_last_ff;
   col_type          s1_value_ff;

   // aggregate state
   logic [COL_W-1:0] acc_ff, acc_in;
   count_type        pass_cnt_ff, pass_cnt_in;
   count_type        val_cnt_ff, val_cnt_in;

   // divider
   logic [COL_W-1:0]   dvd_ff, dvd_in;
   count_type          rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic [COUNT_W:0]   rem_shift, rem_diff;
   logic               q_bit;
   logic [COL_W-1:0]   quot;

   // result register
   col_type          out_val_ff, out_val_in;
   count_type        out_pass_ff, out_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff    <= FN_COUNT_STAR;
         agg_col_ff <= '0;
         c1_col_ff  <= COL_NONE;
         c1_val_ff  <= '0;
         c2_col_ff  <= COL_NONE;
         c2_val_ff  <= '0;
         ops_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AGG_FUNCTION:       func_ff    <= csr_wdata[2:0];
            CSR_AGG_COLUMN:         agg_col_ff <= csr_wdata[1:0];
            CSR_FIRST_COND_COLUMN:  c1_col_ff  <= csr_wdata[2:0];
            CSR_FIRST_COND_VALUE:   c1_val_ff  <= $signed(csr_wdata[COL_W-1:0]);
            CSR_SECOND_COND_COLUMN: c2_col_ff  <= csr_wdata[2:0];
            CSR_SECOND_COND_VALUE:  c2_val_ff  <= $signed(csr_wdata[COL_W-1:0]);
            CSR_COND_OPS:           ops_ff     <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign cols[0] = req_col_zero;
   assign cols[1] = req_col_one;
   assign cols[2] = req_col_two;
   assign cols[3] = req_col_three;

   always_comb begin
      r1 = col_is_int(c1_col_ff, req_int_present) &&
           rel_true(ops_ff[2:0], cols[c1_col_ff[1:0]], c1_val_ff);
      r2 = col_is_int(c2_col_ff, req_int_present) &&
           rel_true(ops_ff[5:3], cols[c2_col_ff[1:0]], c2_val_ff);
      if (c1_col_ff[2])
         pass = 1'b1;
      else if (c2_col_ff[2])
         pass = r1;
      else if (ops_ff[6])
         pass = r1 || r2;
      else
         pass = r1 && r2;
      agg_int = col_is_int({1'b0, agg_col_ff}, req_int_present);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s1_pass_ff  <= pass;
         s1_use_ff   <= pass && agg_int;
         s1_last_ff  <= req_last_row;
         s1_value_ff <= cols[agg_col_ff];
      end
   end

   // fold one row into the aggregate state, or clear it when the result is loaded
   always_comb begin
      acc_in      = acc_ff;
      pass_cnt_in = pass_cnt_ff;
      val_cnt_in  = val_cnt_ff;
      if (cmd.clear) begin
         acc_in      = '0;
         pass_cnt_in = '0;
         val_cnt_in  = '0;
      end else if (cmd.fold) begin
         if (s1_pass_ff && (pass_cnt_ff != '1))
            pass_cnt_in = pass_cnt_ff + 1'b1;
         if (s1_use_ff) begin
            case (func_ff)
               FN_SUM, FN_AVG: acc_in = acc_ff + s1_value_ff;
               FN_MIN: begin
                  if ((val_cnt_ff == '0) || (s1_value_ff < $signed(acc_ff)))
                     acc_in = s1_value_ff;
               end
               FN_MAX: begin
                  if ((val_cnt_ff == '0) || (s1_value_ff > $signed(acc_ff)))
                     acc_in = s1_value_ff;
               end
               default: ;
            endcase
            if (val_cnt_ff != '1)
               val_cnt_in = val_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         pass_cnt_ff <= '0;
         val_cnt_ff  <= '0;
      end else begin
         acc_ff      <= acc_in;
         pass_cnt_ff <= pass_cnt_in;
         val_cnt_ff  <= val_cnt_in;
      end
   end

   // restoring division of |sum| by the value count, one quotient bit a step
   assign rem_shift = {rem_ff, dvd_ff[COL_W-1]};
   assign rem_diff  = rem_shift - {1'b0, val_cnt_ff};
   assign q_bit     = (rem_shift >= {1'b0, val_cnt_ff});
   assign quot      = neg_ff ? (COL_W'(0) - dvd_ff) : dvd_ff;

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      if (cmd.div_start) begin
         dvd_in = acc_ff[COL_W-1] ? (COL_W'(0) - acc_ff) : acc_ff;
         rem_in = '0;
         neg_in = acc_ff[COL_W-1];
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[COL_W-2:0], q_bit};
         rem_in = q_bit ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      out_val_in = '0;
      case (func_ff)
         FN_COUNT_STAR, FN_COUNT: out_val_in = $signed({{(COL_W-COUNT_W){1'b0}}, pass_cnt_ff});
         FN_SUM, FN_MIN, FN_MAX: begin
            if (val_cnt_ff != '0)
               out_val_in = $signed(acc_ff);
         end
         FN_AVG: begin
            if (val_cnt_ff != '0)
               out_val_in = $signed(quot);
         end
         default: out_val_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_val_ff  <= out_val_in;
         out_pass_ff <= pass_cnt_ff;
         out_used_ff <= val_cnt_ff;
      end
   end

   assign sts.s1_last   = s1_last_ff;
   assign sts.need_div  = (func_ff == FN_AVG) && (val_cnt_ff != '0);

   assign rsp_agg_value    = out_val_ff;
   assign rsp_matched_rows = out_pass_ff;
   assign rsp_values_used  = out_used_ff;

endmodule
`default_nettype wire
